// ===== rtl/tcge_pkg.sv =====
// Shared types, codes and defaults of the text cell glyph expander.
`timescale 1ns / 1ps
`default_nettype none

package tcge_pkg;

  localparam int DEF_GLYPH_COUNT  = 256;
  localparam int DEF_PALETTE_SIZE = 16;
  localparam int DEF_QUEUE_DEPTH  = 4;
  localparam int FB_MAX_DIM       = 4096;

  // input item kinds
  localparam logic [1:0] KIND_GLYPH   = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_DRAW    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_OFFSET_X    = 3'd0;
  localparam logic [2:0] CFG_OFFSET_Y    = 3'd1;
  localparam logic [2:0] CFG_FB_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_FB_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_CELL_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_CELL_HEIGHT = 3'd5;

  typedef enum logic [1:0] {
    OP_GLYPH,
    OP_PALETTE,
    OP_DRAW
  } op_t;

  // current geometry, framebuffer size already saturated
  typedef struct packed {
    logic [11:0] off_x;
    logic [11:0] off_y;
    logic [13:0] fb_w;
    logic [13:0] fb_h;
    logic [5:0]  cell_w;
    logic [5:0]  cell_h;
  } geom_t;

  // placement of a cell along one axis
  typedef struct packed {
    logic        ok;
    logic [12:0] start;
    logic [2:0]  n_m1;
  } fit_t;

  // one queued operation for the pixel sequencer
  typedef struct packed {
    op_t         op;
    logic [7:0]  symbol;
    logic [3:0]  color_index;
    logic [2:0]  glyph_row;
    logic [7:0]  glyph_bits;
    logic [31:0] palette_color;
    logic [12:0] x0;
    logic [12:0] y0;
    logic [2:0]  nx_m1;
    logic [2:0]  ny_m1;
    logic        sym_ok;
    logic        cidx_ok;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/tcge_ram.sv =====
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tcge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcge_front.sv =====
// Front end: accepts items, places cells and drops items that do nothing.
`timescale 1ns / 1ps
`default_nettype none

module tcge_front import tcge_pkg::*; #(
  parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT,
  parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  geom_t       geom,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  cell_col,
  input  logic [7:0]  cell_row,
  input  logic [7:0]  symbol,
  input  logic [3:0]  color_index,
  input  logic [2:0]  glyph_row,
  input  logic [7:0]  glyph_bits,
  input  logic [31:0] palette_color,
  output logic        q_push,
  output entry_t      q_data,
  input  logic        q_full
);

  logic        a_valid;
  logic [1:0]  a_kind;
  logic [13:0] a_px;
  logic [13:0] a_py;
  logic [7:0]  a_symbol;
  logic [3:0]  a_cidx;
  logic [2:0]  a_grow;
  logic [7:0]  a_gbits;
  logic [31:0] a_pcolor;

  fit_t fx;
  fit_t fy;
  logic sym_ok;
  logic cidx_ok;
  logic keep;
  logic a_done;
  logic accept;

  // origin = prod + off + (pitch - 8) / 2, truncated toward zero
  function automatic fit_t axis_fit(input logic [13:0] prod, input logic [5:0] pitch,
                                    input logic [11:0] off, input logic [13:0] lim);
    logic [7:0]  d;
    logic [7:0]  c;
    logic [16:0] o;
    logic [15:0] diff;
    fit_t        f;
    d = {2'b00, pitch} - 8'd8;
    c = d + {7'd0, d[7]};
    c = {c[7], c[7:1]};
    o = {3'b000, prod} + {{5{off[11]}}, off} + {{9{c[7]}}, c};
    diff = {2'b00, lim} - o[15:0];
    f.ok = !o[16] && (o[15:0] < {2'b00, lim});
    f.start = o[12:0];
    f.n_m1 = (diff >= 16'd8) ? 3'd7 : 3'(diff - 16'd1);
    return f;
  endfunction

  // hold off the sender while in reset
  assign accept   = in_valid && !in_stall;
  assign in_stall = rst || (a_valid && !a_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_done) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind   <= kind;
      a_px     <= 14'(cell_col * geom.cell_w);
      a_py     <= 14'(cell_row * geom.cell_h);
      a_symbol <= symbol;
      a_cidx   <= color_index;
      a_grow   <= glyph_row;
      a_gbits  <= glyph_bits;
      a_pcolor <= palette_color;
    end
  end

  always_comb begin
    fx      = axis_fit(a_px, geom.cell_w, geom.off_x, geom.fb_w);
    fy      = axis_fit(a_py, geom.cell_h, geom.off_y, geom.fb_h);
    sym_ok  = {24'd0, a_symbol} < 32'(GLYPH_COUNT);
    cidx_ok = {28'd0, a_cidx} < 32'(PALETTE_SIZE);
    q_data.op = OP_GLYPH;
    keep      = 1'b0;
    unique case (a_kind)
      KIND_GLYPH: begin
        q_data.op = OP_GLYPH;
        keep      = sym_ok;
      end
      KIND_PALETTE: begin
        q_data.op = OP_PALETTE;
        keep      = cidx_ok;
      end
      KIND_DRAW: begin
        q_data.op = OP_DRAW;
        keep      = fx.ok && fy.ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    q_data.symbol        = a_symbol;
    q_data.color_index   = a_cidx;
    q_data.glyph_row     = a_grow;
    q_data.glyph_bits    = a_gbits;
    q_data.palette_color = a_pcolor;
    q_data.x0            = fx.start;
    q_data.y0            = fy.start;
    q_data.nx_m1         = fx.n_m1;
    q_data.ny_m1         = fy.n_m1;
    q_data.sym_ok        = sym_ok;
    q_data.cidx_ok       = cidx_ok;
  end

  // drop items that change nothing, queue the rest
  assign a_done = a_valid && (!keep || !q_full);
  assign q_push = a_valid && keep && !q_full;

endmodule

`default_nettype wire

// ===== rtl/tcge_queue.sv =====
// Short queue of operations between the front end and the pixel sequencer.
`timescale 1ns / 1ps
`default_nettype none

module tcge_queue import tcge_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   nonempty
);

  entry_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty) else $error("queue popped while empty");
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count past depth");
`endif

endmodule

`default_nettype wire

// ===== rtl/tcge_back.sv =====
// Back end: writes the glyph and palette stores and walks cells pixel by pixel.
`timescale 1ns / 1ps
`default_nettype none

module tcge_back import tcge_pkg::*; #(
  parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT,
  parameter int PALETTE_SIZE = DEF_PALETTE_SIZE,
  localparam int GAW = $clog2(GLYPH_COUNT * 8),
  localparam int PAW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [13:0] fb_w,
  input  logic        q_valid,
  input  entry_t      q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] pixel_address,
  output logic [31:0] pixel_color,
  output logic        last
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

  state_t      state;
  state_t      state_next;
  entry_t      cur;
  logic [2:0]  x;
  logic [2:0]  y;
  logic [23:0] row_addr;
  logic [23:0] base_prod;

  logic        emit;
  logic        row_end;
  logic        cell_end;
  logic        glyph_we;
  logic        pal_we;
  logic        glyph_re;
  logic        pal_re;
  logic [2:0]  rd_row;
  logic [7:0]  glyph_q;
  logic [31:0] pal_q;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign glyph_we = q_pop && (q_head.op == OP_GLYPH);
  assign pal_we   = q_pop && (q_head.op == OP_PALETTE);

  assign emit     = (state == ST_RUN) && (!out_valid || !out_stall);
  assign row_end  = (x == cur.nx_m1);
  assign cell_end = row_end && (y == cur.ny_m1);

  // fetch row 0 at setup, then the next row as each row finishes
  assign rd_row   = (state == ST_SETUP) ? 3'd0 : y + 3'd1;
  assign glyph_re = (state == ST_SETUP) || (emit && row_end && !cell_end);
  assign pal_re   = (state == ST_SETUP);

  // origin row is below the saturated height, so the product fits 24 bits
  assign base_prod = 24'(cur.y0) * 24'(fb_w);

  tcge_ram #(
    .WIDTH (8),
    .DEPTH (GLYPH_COUNT * 8)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (glyph_we),
    .waddr (GAW'({q_head.symbol, q_head.glyph_row})),
    .wdata (q_head.glyph_bits),
    .re    (glyph_re),
    .raddr (GAW'({cur.symbol, rd_row})),
    .rdata (glyph_q)
  );

  tcge_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_SIZE)
  ) u_palette_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (PAW'(q_head.color_index)),
    .wdata (q_head.palette_color),
    .re    (pal_re),
    .raddr (PAW'(cur.color_index)),
    .rdata (pal_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_pop && (q_head.op == OP_DRAW)) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (emit && cell_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (state == ST_SETUP) begin
      row_addr <= base_prod + {11'd0, cur.x0};
      x        <= 3'd0;
      y        <= 3'd0;
    end else if (emit) begin
      if (row_end) begin
        x        <= 3'd0;
        y        <= y + 3'd1;
        row_addr <= row_addr + {10'd0, fb_w};
      end else begin
        x <= x + 3'd1;
      end
    end
    if (emit) begin
      pixel_address <= row_addr + {21'd0, x};
      pixel_color   <= (cur.sym_ok && cur.cidx_ok && glyph_q[x]) ? pal_q : 32'd0;
      last          <= cell_end;
    end
  end

`ifndef SYNTHESIS
  a_last_ends_cell: assert property (@(posedge clk) disable iff (rst)
    (emit && cell_end) |=> (state == ST_IDLE)) else $error("cell did not end after last");
  a_setup_then_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SETUP) |=> (state == ST_RUN && x == 3'd0 && y == 3'd0))
    else $error("setup did not start a cell walk");
  a_walk_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (x <= cur.nx_m1 && y <= cur.ny_m1))
    else $error("pixel walk left the clipped cell");
`endif

endmodule

`default_nettype wire

// ===== rtl/text_cell_glyph_expander.sv =====
// Top level of the text cell glyph expander: configuration registers and wiring.
//
//   channel  signals                                 direction  transfer when
//   in       in_valid, in_stall, kind .. palette_color  input   in_valid & !in_stall
//   out      out_valid, out_stall, pixel_address,    output     out_valid & !out_stall
//            pixel_color, last
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  input   cfg_valid & cfg_ready
//
// The front end takes one item a cycle while the queue has room.
// The sequencer writes a load from its idle state; a drawn cell takes a setup step
// that fetches glyph row 0, then one pixel a cycle while the output is not stalled.
// Cells outside the framebuffer and ignored items never reach the sequencer.
// Reset is synchronous and holds off input and configuration; stores are not cleared.
// A stalled output holds the sequencer; a full queue stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module text_cell_glyph_expander import tcge_pkg::*; #(
  parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT,
  parameter int PALETTE_SIZE = DEF_PALETTE_SIZE,
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  cell_col,
  input  logic [7:0]  cell_row,
  input  logic [7:0]  symbol,
  input  logic [3:0]  color_index,
  input  logic [2:0]  glyph_row,
  input  logic [7:0]  glyph_bits,
  input  logic [31:0] palette_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] pixel_address,
  output logic [31:0] pixel_color,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic [11:0] offset_x;
  logic [11:0] offset_y;
  logic [12:0] fb_width;
  logic [12:0] fb_height;
  logic [5:0]  cell_width;
  logic [5:0]  cell_height;

  geom_t  geom;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_nonempty;
  entry_t q_data;
  entry_t q_head;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x    <= 12'd32;
      offset_y    <= 12'd32;
      fb_width    <= 13'd640;
      fb_height   <= 13'd480;
      cell_width  <= 6'd8;
      cell_height <= 6'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OFFSET_X:    offset_x    <= cfg_data[11:0];
        CFG_OFFSET_Y:    offset_y    <= cfg_data[11:0];
        CFG_FB_WIDTH:    fb_width    <= cfg_data;
        CFG_FB_HEIGHT:   fb_height   <= cfg_data;
        CFG_CELL_WIDTH:  cell_width  <= cfg_data[5:0];
        CFG_CELL_HEIGHT: cell_height <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // saturate the framebuffer size at the largest supported dimension
  always_comb begin
    geom.off_x  = offset_x;
    geom.off_y  = offset_y;
    geom.fb_w   = ({1'b0, fb_width} > 14'(FB_MAX_DIM)) ? 14'(FB_MAX_DIM) : {1'b0, fb_width};
    geom.fb_h   = ({1'b0, fb_height} > 14'(FB_MAX_DIM)) ? 14'(FB_MAX_DIM)
                                                         : {1'b0, fb_height};
    geom.cell_w = cell_width;
    geom.cell_h = cell_height;
  end

  tcge_front #(
    .GLYPH_COUNT  (GLYPH_COUNT),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .geom          (geom),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .cell_col      (cell_col),
    .cell_row      (cell_row),
    .symbol        (symbol),
    .color_index   (color_index),
    .glyph_row     (glyph_row),
    .glyph_bits    (glyph_bits),
    .palette_color (palette_color),
    .q_push        (q_push),
    .q_data        (q_data),
    .q_full        (q_full)
  );

  tcge_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_nonempty)
  );

  tcge_back #(
    .GLYPH_COUNT  (GLYPH_COUNT),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .fb_w          (geom.fb_w),
    .q_valid       (q_nonempty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last          (last)
  );

endmodule

`default_nettype wire
